>>> rtl/core/dll_pkg.sv
// Shared constants, codes and types of the doubly linked list manager.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package dll_pkg;

  localparam int NODES  = 64;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  // Operation codes
  localparam func_t FN_PUSH_FRONT = 3'd0;
  localparam func_t FN_PUSH_BACK  = 3'd1;
  localparam func_t FN_POP_FRONT  = 3'd2;
  localparam func_t FN_POP_BACK   = 3'd3;
  localparam func_t FN_REMOVE     = 3'd4;
  localparam func_t FN_QUERY      = 3'd5;

  // Status codes
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_EMPTY      = 2'd1;
  localparam status_t ST_LINKED     = 2'd2;
  localparam status_t ST_NOT_LINKED = 2'd3;

endpackage

>>> rtl/core/dll_if.sv
// Valid/ready channel interfaces of the doubly linked list manager.
// Depends on dll_pkg for payload types.
interface dll_req_if;
  logic           valid;
  logic           ready;
  dll_pkg::func_t func;
  dll_pkg::node_t node_id;

  modport source (output valid, output func, output node_id, input ready);
  modport sink   (input valid, input func, input node_id, output ready);
endinterface

interface dll_rsp_if;
  logic             valid;
  logic             ready;
  dll_pkg::node_t   result_node;
  dll_pkg::status_t status;
  logic             on_list;
  dll_pkg::count_t  entry_count;

  modport source (output valid, output result_node, output status, output on_list,
                  output entry_count, input ready);
  modport sink   (input valid, input result_node, input status, input on_list,
                  input entry_count, output ready);
endinterface

>>> rtl/core/doubly_linked_list_manager.sv
// Doubly linked list manager: one deque over a pool of numbered nodes.
// Depends on dll_pkg and on the dll_req_if / dll_rsp_if channel interfaces.
//
//   channel | dir | payload                                      | transaction when
//   --------+-----+----------------------------------------------+------------------
//   req     | in  | func, node_id                                | valid & ready
//   rsp     | out | result_node, status, on_list, entry_count    | valid & ready
//
// One transaction per cycle sustained while rsp is not stalled; a taken request is held
// in the executing-operation register and its result in the result register. Execution
// relies on the registered read of the next/prev pointer memories: the read is issued as
// the request is taken, using the head/tail that the operation now executing will leave,
// and a write in the same cycle to that address is forwarded into the read register.
// Reset (rst, synchronous) empties the list and clears all membership bits at once;
// the pointer memories are not cleared. A stalled rsp holds the executing operation,
// which in turn holds req.ready low; no state changes while stalled.
module doubly_linked_list_manager (
  input  logic             clk,
  input  logic             rst,
  dll_req_if.sink          req,
  dll_rsp_if.source        rsp
);

  // Pointer memories and their registered read data
  dll_pkg::node_t nxt_mem [dll_pkg::NODES];
  dll_pkg::node_t prv_mem [dll_pkg::NODES];
  dll_pkg::node_t nxt_rd;
  dll_pkg::node_t prv_rd;

  // List state
  logic [dll_pkg::NODES-1:0] linked;
  dll_pkg::node_t            head;
  dll_pkg::node_t            tail;
  dll_pkg::count_t           count;

  // Executing operation
  logic           op_valid;
  dll_pkg::func_t op_func;
  dll_pkg::node_t op_node;

  // Result register
  logic             out_valid;
  dll_pkg::node_t   out_node;
  dll_pkg::status_t out_status;
  logic             out_on;
  dll_pkg::count_t  out_count;

  // Execute-stage results
  logic             exec;
  logic             req_accept;
  dll_pkg::node_t   tgt;
  dll_pkg::node_t   res_node;
  dll_pkg::status_t res_status;
  logic             res_on;
  dll_pkg::node_t   head_next;
  dll_pkg::node_t   tail_next;
  dll_pkg::count_t  count_next;
  logic             do_unlink;
  logic             set_flag;
  logic             nxt_we;
  dll_pkg::node_t   nxt_wa;
  dll_pkg::node_t   nxt_wd;
  logic             prv_we;
  dll_pkg::node_t   prv_wa;
  dll_pkg::node_t   prv_wd;
  dll_pkg::node_t   head_fwd;
  dll_pkg::node_t   tail_fwd;
  dll_pkg::node_t   rd_addr;

  // Advance the executing operation whenever the result register is free or drains.
  assign exec       = op_valid && (!out_valid || rsp.ready);
  assign req.ready  = !op_valid || exec;
  assign req_accept = req.valid && req.ready;

  // Pops unlink the head or tail; remove unlinks the named node.
  always_comb begin
    case (op_func)
      dll_pkg::FN_POP_FRONT: tgt = head;
      dll_pkg::FN_POP_BACK:  tgt = tail;
      default:               tgt = op_node;
    endcase
  end

  // Single-pass execution of one operation against the current state.
  always_comb begin
    res_node   = op_node;
    res_status = dll_pkg::ST_OK;
    res_on     = 1'b0;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    do_unlink  = 1'b0;
    set_flag   = 1'b0;
    nxt_we     = 1'b0;
    nxt_wa     = op_node;
    nxt_wd     = head;
    prv_we     = 1'b0;
    prv_wa     = head;
    prv_wd     = op_node;

    case (op_func)
      dll_pkg::FN_PUSH_FRONT, dll_pkg::FN_PUSH_BACK: begin
        if (linked[op_node]) begin
          res_status = dll_pkg::ST_LINKED;
        end else begin
          set_flag   = 1'b1;
          count_next = count + 1'b1;
          if (count == '0) begin
            head_next = op_node;
            tail_next = op_node;
          end else if (op_func == dll_pkg::FN_PUSH_FRONT) begin
            // New node points forward to old head; old head points back to it.
            nxt_we    = 1'b1;
            nxt_wa    = op_node;
            nxt_wd    = head;
            prv_we    = 1'b1;
            prv_wa    = head;
            prv_wd    = op_node;
            head_next = op_node;
          end else begin
            prv_we    = 1'b1;
            prv_wa    = op_node;
            prv_wd    = tail;
            nxt_we    = 1'b1;
            nxt_wa    = tail;
            nxt_wd    = op_node;
            tail_next = op_node;
          end
        end
      end
      dll_pkg::FN_POP_FRONT, dll_pkg::FN_POP_BACK: begin
        if (count == '0) begin
          res_status = dll_pkg::ST_EMPTY;
          res_node   = '0;
        end else begin
          res_node  = tgt;
          do_unlink = 1'b1;
        end
      end
      dll_pkg::FN_REMOVE: begin
        if (!linked[op_node]) begin
          res_status = dll_pkg::ST_NOT_LINKED;
        end else begin
          do_unlink = 1'b1;
        end
      end
      dll_pkg::FN_QUERY: begin
        res_on = linked[op_node];
      end
      default: begin
        // Unused codes: answer with the node and change nothing.
      end
    endcase

    // Splice the target out: its neighbors (read from memory) point at each other.
    if (do_unlink) begin
      count_next = count - 1'b1;
      if (tgt == head) begin
        head_next = nxt_rd;
      end else begin
        nxt_we = 1'b1;
        nxt_wa = prv_rd;
        nxt_wd = nxt_rd;
      end
      if (tgt == tail) begin
        tail_next = prv_rd;
      end else begin
        prv_we = 1'b1;
        prv_wa = nxt_rd;
        prv_wd = prv_rd;
      end
    end
  end

  // Read address of the incoming request sees head/tail after the executing operation.
  assign head_fwd = exec ? head_next : head;
  assign tail_fwd = exec ? tail_next : tail;

  always_comb begin
    case (req.func)
      dll_pkg::FN_POP_FRONT: rd_addr = head_fwd;
      dll_pkg::FN_POP_BACK:  rd_addr = tail_fwd;
      default:               rd_addr = req.node_id;
    endcase
  end

  // Pointer memories: one write and one registered read each, write-first forwarding.
  always_ff @(posedge clk) begin
    if (exec && nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (req_accept) begin
      if (exec && nxt_we && (nxt_wa == rd_addr)) begin
        nxt_rd <= nxt_wd;
      end else begin
        nxt_rd <= nxt_mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (req_accept) begin
      if (exec && prv_we && (prv_wa == rd_addr)) begin
        prv_rd <= prv_wd;
      end else begin
        prv_rd <= prv_mem[rd_addr];
      end
    end
  end

  // Control and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      out_valid <= 1'b0;
      linked    <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
    end else begin
      if (req_accept) begin
        op_valid <= 1'b1;
      end else if (exec) begin
        op_valid <= 1'b0;
      end

      if (exec) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (exec) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
        if (set_flag) begin
          linked[op_node] <= 1'b1;
        end
        if (do_unlink) begin
          linked[tgt] <= 1'b0;
        end
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_func <= req.func;
      op_node <= req.node_id;
    end
    if (exec) begin
      out_node   <= res_node;
      out_status <= res_status;
      out_on     <= res_on;
      out_count  <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_node = out_node;
  assign rsp.status      = out_status;
  assign rsp.on_list     = out_on;
  assign rsp.entry_count = out_count;

`ifndef SYNTHESIS
  // Count tracks the membership bits.
  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    count == dll_pkg::count_t'($countones(linked)))
    else $error("list count differs from number of linked nodes");

  // Head and tail of a non-empty list are members.
  a_ends_linked: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (linked[head] && linked[tail]))
    else $error("head or tail of non-empty list not linked");

  // A single-node list has head equal to tail.
  a_single_node: assert property (@(posedge clk) disable iff (rst)
    (count == dll_pkg::count_t'(1)) |-> (head == tail))
    else $error("single-node list with head and tail apart");

  // A successful push leaves the node linked.
  a_push_links: assert property (@(posedge clk) disable iff (rst)
    (exec && set_flag) |=> linked[$past(op_node)])
    else $error("pushed node not linked");

  // A stalled operation changes no list state.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !exec) |=> ($stable(head) && $stable(tail) && $stable(count)))
    else $error("list state changed while stalled");
`endif

endmodule
